### rtl/core/dpu_pkg.sv
// Package for the depth pixel unprojection block: widths, register map, payload types.
package dpu_pkg;

  localparam int COORD_BITS = 12;
  localparam int DEPTH_BITS = 16;
  localparam int POINT_BITS = 20;

  // register widths
  localparam int INV_FOCAL_W = 24;
  localparam int CENTER_W    = 16;
  localparam int COEF_W      = 16;
  localparam int ROT_ROW_W   = 3 * COEF_W;
  localparam int CFG_DATA_W  = ROT_ROW_W;
  localparam int CFG_IDX_W   = 3;

  // register reset values
  localparam logic [INV_FOCAL_W-1:0] INV_FOCAL_RST  = 24'd33554;
  localparam logic [CENTER_W-1:0]    CENTER_COL_RST = 16'd5120;
  localparam logic [CENTER_W-1:0]    CENTER_ROW_RST = 16'd3840;
  localparam logic [ROT_ROW_W-1:0]   ROT_ROW0_RST   = 48'h0000_0000_4000;
  localparam logic [ROT_ROW_W-1:0]   ROT_ROW1_RST   = 48'h0000_4000_0000;
  localparam logic [ROT_ROW_W-1:0]   ROT_ROW2_RST   = 48'h4000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_FOCAL     = 3'd0,
    CFG_CENTER_COL    = 3'd1,
    CFG_CENTER_ROW    = 3'd2,
    CFG_ROT_ROW0      = 3'd3,
    CFG_ROT_ROW1      = 3'd4,
    CFG_ROT_ROW2      = 3'd5,
    CFG_ROTATE_ENABLE = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [INV_FOCAL_W-1:0]      inv_focal;
    logic [CENTER_W-1:0]         center_col;
    logic [CENTER_W-1:0]         center_row;
    logic [2:0][ROT_ROW_W-1:0]   rot_row;
    logic                        rotate_enable;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
    logic [DEPTH_BITS-1:0] depth_value;
  } pixel_t;

  typedef struct packed {
    logic signed [POINT_BITS-1:0] point_x;
    logic signed [POINT_BITS-1:0] point_y;
    logic signed [POINT_BITS-1:0] point_z;
  } point_t;

endpackage

### rtl/core/dpu_cfg_regs.sv
// Configuration register file: camera intrinsics, rotation rows, rotate enable.
module dpu_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dpu_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dpu_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output dpu_pkg::cfg_t                      cfg_o
);

  dpu_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_focal     <= dpu_pkg::INV_FOCAL_RST;
      cfg_q.center_col    <= dpu_pkg::CENTER_COL_RST;
      cfg_q.center_row    <= dpu_pkg::CENTER_ROW_RST;
      cfg_q.rot_row[0]    <= dpu_pkg::ROT_ROW0_RST;
      cfg_q.rot_row[1]    <= dpu_pkg::ROT_ROW1_RST;
      cfg_q.rot_row[2]    <= dpu_pkg::ROT_ROW2_RST;
      cfg_q.rotate_enable <= 1'b0;
    end else if (cfg_we_i) begin
      // unknown index: write dropped
      unique case (dpu_pkg::cfg_idx_e'(cfg_idx_i))
        dpu_pkg::CFG_INV_FOCAL:
          cfg_q.inv_focal <= cfg_data_i[dpu_pkg::INV_FOCAL_W-1:0];
        dpu_pkg::CFG_CENTER_COL:
          cfg_q.center_col <= cfg_data_i[dpu_pkg::CENTER_W-1:0];
        dpu_pkg::CFG_CENTER_ROW:
          cfg_q.center_row <= cfg_data_i[dpu_pkg::CENTER_W-1:0];
        dpu_pkg::CFG_ROT_ROW0:
          cfg_q.rot_row[0] <= cfg_data_i[dpu_pkg::ROT_ROW_W-1:0];
        dpu_pkg::CFG_ROT_ROW1:
          cfg_q.rot_row[1] <= cfg_data_i[dpu_pkg::ROT_ROW_W-1:0];
        dpu_pkg::CFG_ROT_ROW2:
          cfg_q.rot_row[2] <= cfg_data_i[dpu_pkg::ROT_ROW_W-1:0];
        dpu_pkg::CFG_ROTATE_ENABLE:
          cfg_q.rotate_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/depth_pixel_to_point_unproject_top.sv
// Top level: six-stage pipeline back-projecting depth pixels to 3-D points.
// Each pixel passes through six register stages on its way to out_valid_o.
// Throughput: one pixel per cycle when the output is not stalled; each stage
// holds one item and moves on as soon as the next stage is empty or moving, so
// bubbles collapse under stalls.
// Zero-depth pixels are accepted and dropped at stage 1 (no output transfer).
// Reset (rst_ni low, async) empties the pipeline and loads register defaults.
module depth_pixel_to_point_unproject_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // pixel input
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  dpu_pkg::pixel_t                in_data_i,
  // point output
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output dpu_pkg::point_t                out_data_o,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [dpu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dpu_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int NSTG = 6;
  localparam int CB   = dpu_pkg::COORD_BITS;
  localparam int DB   = dpu_pkg::DEPTH_BITS;
  localparam int PB   = dpu_pkg::POINT_BITS;
  localparam int CW   = dpu_pkg::COEF_W;

  // Q.4 pixel offset, signed
  localparam int DX_W  = ((CB + 4 > dpu_pkg::CENTER_W) ? CB + 4 : dpu_pkg::CENTER_W) + 1;
  localparam int IF_W  = dpu_pkg::INV_FOCAL_W + 1;  // inv_focal as signed
  localparam int PU_W  = DX_W + IF_W;               // dx * inv_f
  localparam int U_W   = PU_W + 1 - 8;              // u, Q.20
  localparam int D_W   = DB + 1;                    // depth as signed
  localparam int PC_W  = U_W + D_W;                 // u * d
  localparam int CAM_W = PC_W + 1 - 16;             // camera point, Q.4
  localparam int RP_W  = CW + CAM_W;                // coef * cam
  localparam int ACC_W = RP_W + 2;                  // sum of three
  localparam int RO_W  = ACC_W + 1 - 18;            // rotated, whole units
  localparam int NR_W  = CAM_W + 1 - 4;             // unrotated, whole units

  localparam logic signed [RO_W-1:0] SAT_HI =
    RO_W'((64'sd1 <<< (PB - 1)) - 64'sd1);
  localparam logic signed [RO_W-1:0] SAT_LO = -SAT_HI - RO_W'(1);

  dpu_pkg::cfg_t cfg;

  dpu_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // ---------------------------------------------------------------------------
  // Flow control: one valid bit per stage, stage k loads when it is empty or
  // when stage k+1 can take its item.
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] vld_q, vld_d;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !vld_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (rdy[0]) begin
      vld_d[0] = in_valid_i && (in_data_i.depth_value != '0);
    end
    for (int k = 1; k < NSTG; k++) begin
      if (rdy[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NSTG-1];

  // ---------------------------------------------------------------------------
  // Stage 1: offsets from the principal point, Q.4
  // ---------------------------------------------------------------------------
  logic signed [DX_W-1:0] col_s, row_s, cc_s, cr_s;
  logic signed [DX_W-1:0] dx_d, dy_d, dx_q, dy_q;
  logic [DB-1:0]          d1_q;

  always_comb begin
    col_s = DX_W'({in_data_i.pixel_col, 4'b0000});
    row_s = DX_W'({in_data_i.pixel_row, 4'b0000});
    cc_s  = DX_W'(cfg.center_col);
    cr_s  = DX_W'(cfg.center_row);
    dx_d  = col_s - cc_s;
    dy_d  = row_s - cr_s;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      d1_q <= in_data_i.depth_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: u = round(dx * inv_f / 2^8), v likewise
  // ---------------------------------------------------------------------------
  logic signed [IF_W-1:0] invf_s;
  logic signed [PU_W-1:0] pu, pv;
  logic signed [PU_W:0]   pu_r, pv_r;
  logic signed [U_W-1:0]  u_q, v_q;
  logic [DB-1:0]          d2_q;

  always_comb begin
    invf_s = IF_W'(cfg.inv_focal);
    pu     = PU_W'(dx_q) * PU_W'(invf_s);
    pv     = PU_W'(dy_q) * PU_W'(invf_s);
    pu_r   = (PU_W + 1)'(pu) + (PU_W + 1)'(128);
    pv_r   = (PU_W + 1)'(pv) + (PU_W + 1)'(128);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      u_q  <= U_W'(pu_r >>> 8);
      v_q  <= U_W'(pv_r >>> 8);
      d2_q <= d1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: u * d, v * d (Q.20 times depth units)
  // ---------------------------------------------------------------------------
  logic signed [D_W-1:0]  d2_s;
  logic signed [PC_W-1:0] pcx_q, pcy_q;
  logic [DB-1:0]          d3_q;

  assign d2_s = D_W'(d2_q);

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      pcx_q <= PC_W'(u_q) * PC_W'(d2_s);
      pcy_q <= PC_W'(v_q) * PC_W'(d2_s);
      d3_q  <= d2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: camera point in Q.4, then the nine matrix products and the
  // unrotated rounding in parallel
  // ---------------------------------------------------------------------------
  logic signed [PC_W:0]    pcx_r, pcy_r;
  logic signed [CAM_W-1:0] cam [3];
  logic signed [CAM_W:0]   cam_r [3];
  logic signed [CW-1:0]    coef [3][3];
  logic signed [RP_W-1:0]  rp_q [3][3];
  logic signed [NR_W-1:0]  nr_q [3];

  always_comb begin
    pcx_r  = (PC_W + 1)'(pcx_q) + (PC_W + 1)'(1 << 15);
    pcy_r  = (PC_W + 1)'(pcy_q) + (PC_W + 1)'(1 << 15);
    cam[0] = CAM_W'(pcx_r >>> 16);
    cam[1] = CAM_W'(pcy_r >>> 16);
    cam[2] = CAM_W'({d3_q, 4'b0000});
    for (int i = 0; i < 3; i++) begin
      cam_r[i] = (CAM_W + 1)'(cam[i]) + (CAM_W + 1)'(8);
      for (int j = 0; j < 3; j++) begin
        coef[i][j] = cfg.rot_row[i][CW*j +: CW];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++) begin
        nr_q[i] <= NR_W'(cam_r[i] >>> 4);
        for (int j = 0; j < 3; j++) begin
          rp_q[i][j] <= RP_W'(coef[i][j]) * RP_W'(cam[j]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: row sums, rounding by 2^18, rotation select
  // ---------------------------------------------------------------------------
  logic signed [ACC_W:0]  acc [3];
  logic signed [RO_W-1:0] wide_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = (ACC_W + 1)'(rp_q[i][0]) + (ACC_W + 1)'(rp_q[i][1])
             + (ACC_W + 1)'(rp_q[i][2]) + (ACC_W + 1)'(1 << 17);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      for (int i = 0; i < 3; i++) begin
        wide_q[i] <= cfg.rotate_enable ? RO_W'(acc[i] >>> 18) : RO_W'(nr_q[i]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: saturate to the output width, output register
  // ---------------------------------------------------------------------------
  logic signed [PB-1:0] sat [3];
  dpu_pkg::point_t      out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      priority if (wide_q[i] > SAT_HI) begin
        sat[i] = PB'(SAT_HI);
      end else if (wide_q[i] < SAT_LO) begin
        sat[i] = PB'(SAT_LO);
      end else begin
        sat[i] = PB'(wide_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      out_q.point_x <= sat[0];
      out_q.point_y <= sat[1];
      out_q.point_z <= sat[2];
    end
  end

  assign out_data_o = out_q;

endmodule

### verif/testbench.sv
// Self-checking testbench for the depth pixel to 3-D point unprojection pipeline.
`timescale 1ns / 100ps

module testbench;
  import dpu_pkg::*;

  // Pipeline depth given at the head of the top level; used for settle waits.
  localparam int PIPE_LATENCY = 6;
  localparam int SETTLE_CYCLES = PIPE_LATENCY + 4;
  // Watchdog: the slowest legal run is far below this.
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_REPORTS = 10;

  // Fixed-point scaling of the unprojection path.
  localparam int SUBPIX_BITS = 4;   // Q.4 pixel and camera coordinates
  localparam int FOCAL_SHIFT = 8;   // (dx * inv_focal) -> Q.20 ray slope
  localparam int DEPTH_SHIFT = 16;  // (slope * depth) -> Q.4 coordinate
  localparam int ROT_SHIFT   = 18;  // Q1.14 coefficient times Q.4 -> whole units

  // The one index of the 3-bit register map that decodes to nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  pixel_t                in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  point_t                out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  depth_pixel_to_point_unproject_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 12 ns clock.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Shadow copy of the camera registers, updated on every write.
  cfg_t   cam_cfg;
  // Points the pipeline still owes us, oldest first.
  point_t pending_points[$];
  point_t want_pt;

  // Idle chances in percent per decision; zero means back-to-back transfers.
  int idle_levels[4] = '{0, 5, 20, 40};
  int src_gap_pct    = 0;
  int sink_stall_pct = 0;

  int n_sent     = 0;
  int n_dropped  = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int n_settings = 0;
  int n_cycles   = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Add half an LSB, then floor (>>> on longint is a floor for negatives).
  function automatic longint shift_round(input longint w, input int k);
    return (w + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic logic signed [POINT_BITS-1:0] saturate_point(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (POINT_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      v = hi;
    end else if (v < lo) begin
      v = lo;
    end
    return v[POINT_BITS-1:0];
  endfunction

  // Back-project one pixel under the current shadow registers.
  // Returns 0 for a zero-depth pixel, which yields no point.
  function automatic bit backproject(input pixel_t px, output point_t pt);
    longint depth;
    longint dx;
    longint dy;
    longint u;
    longint v;
    longint acc;
    longint cam[3];
    longint world[3];
    pt = '0;
    if (px.depth_value == '0) begin
      return 1'b0;
    end
    depth = longint'(px.depth_value);
    dx = (longint'(px.pixel_col) <<< SUBPIX_BITS) - longint'(cam_cfg.center_col);
    dy = (longint'(px.pixel_row) <<< SUBPIX_BITS) - longint'(cam_cfg.center_row);
    u = shift_round(dx * longint'(cam_cfg.inv_focal), FOCAL_SHIFT);
    v = shift_round(dy * longint'(cam_cfg.inv_focal), FOCAL_SHIFT);
    cam[0] = shift_round(u * depth, DEPTH_SHIFT);
    cam[1] = shift_round(v * depth, DEPTH_SHIFT);
    cam[2] = depth <<< SUBPIX_BITS;
    for (int i = 0; i < 3; i++) begin
      if (cam_cfg.rotate_enable) begin
        acc = 0;
        for (int j = 0; j < 3; j++) begin
          acc += longint'($signed(cam_cfg.rot_row[i][COEF_W*j +: COEF_W])) * cam[j];
        end
        world[i] = shift_round(acc, ROT_SHIFT);
      end else begin
        world[i] = shift_round(cam[i], SUBPIX_BITS);
      end
    end
    pt.point_x = saturate_point(world[0]);
    pt.point_y = saturate_point(world[1]);
    pt.point_z = saturate_point(world[2]);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Register settings
  // ---------------------------------------------------------------------------

  function automatic cfg_t reset_config();
    cfg_t c;
    c.inv_focal     = INV_FOCAL_RST;
    c.center_col    = CENTER_COL_RST;
    c.center_row    = CENTER_ROW_RST;
    c.rot_row[0]    = ROT_ROW0_RST;
    c.rot_row[1]    = ROT_ROW1_RST;
    c.rot_row[2]    = ROT_ROW2_RST;
    c.rotate_enable = 1'b0;
    return c;
  endfunction

  function automatic logic [CENTER_W-1:0] random_center();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return CENTER_W'($urandom);
      default: return CENTER_W'($urandom_range(100, 3000) * 16 + $urandom_range(0, 15));
    endcase
  endfunction

  // Mix of full-scale, zero, arbitrary and rotation-sized coefficients.
  function automatic logic [ROT_ROW_W-1:0] random_row();
    logic [ROT_ROW_W-1:0] r;
    for (int j = 0; j < 3; j++) begin
      case ($urandom_range(0, 7))
        0:       r[COEF_W*j +: COEF_W] = 16'h7FFF;
        1:       r[COEF_W*j +: COEF_W] = 16'h8000;
        2:       r[COEF_W*j +: COEF_W] = 16'h0000;
        3:       r[COEF_W*j +: COEF_W] = COEF_W'($urandom);
        default: r[COEF_W*j +: COEF_W] = COEF_W'($urandom_range(0, 32768) - 16384);
      endcase
    end
    return r;
  endfunction

  function automatic cfg_t random_config(input bit rotate);
    cfg_t c;
    c = reset_config();
    case ($urandom_range(0, 9))
      0:       c.inv_focal = '0;
      1:       c.inv_focal = '1;
      2:       c.inv_focal = INV_FOCAL_W'($urandom);
      default: c.inv_focal = INV_FOCAL_W'(32'd16777216 / $urandom_range(150, 3000));
    endcase
    c.center_col = random_center();
    c.center_row = random_center();
    if ($urandom_range(0, 3) != 0) begin
      for (int i = 0; i < 3; i++) begin
        c.rot_row[i] = random_row();
      end
    end
    c.rotate_enable = rotate;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Bus tasks
  // ---------------------------------------------------------------------------

  // Drop valid, let every owed point drain, then wait for the pipeline to settle.
  task automatic wait_pipeline_empty();
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write; leaves the write enable high so writes can run
  // back to back. The caller lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_INV_FOCAL:     cam_cfg.inv_focal     = data[INV_FOCAL_W-1:0];
      CFG_CENTER_COL:    cam_cfg.center_col    = data[CENTER_W-1:0];
      CFG_CENTER_ROW:    cam_cfg.center_row    = data[CENTER_W-1:0];
      CFG_ROT_ROW0:      cam_cfg.rot_row[0]    = data;
      CFG_ROT_ROW1:      cam_cfg.rot_row[1]    = data;
      CFG_ROT_ROW2:      cam_cfg.rot_row[2]    = data;
      CFG_ROTATE_ENABLE: cam_cfg.rotate_enable = data[0];
      default: ;  // unmapped index: no register changes
    endcase
  endtask

  // Load a full setting while idle. Narrow registers get junk in the unused
  // upper data bits, which the block must mask away.
  task automatic program_camera(input cfg_t c);
    wait_pipeline_empty();
    write_reg(CFG_INV_FOCAL,  {24'($urandom), c.inv_focal});
    write_reg(CFG_CENTER_COL, {32'($urandom), c.center_col});
    write_reg(CFG_CENTER_ROW, {32'($urandom), c.center_row});
    write_reg(CFG_ROT_ROW0,   c.rot_row[0]);
    write_reg(CFG_ROT_ROW1,   c.rot_row[1]);
    write_reg(CFG_ROT_ROW2,   c.rot_row[2]);
    write_reg(CFG_ROTATE_ENABLE, {47'({$urandom, $urandom}), c.rotate_enable});
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Offer one pixel and hold it until the transfer. Valid is left high;
  // the next call or a drain decides whether it drops.
  task automatic send_pixel(input logic [COORD_BITS-1:0] col,
                            input logic [COORD_BITS-1:0] row,
                            input logic [DEPTH_BITS-1:0] depth);
    pixel_t px;
    point_t pt;
    px.pixel_col   = col;
    px.pixel_row   = row;
    px.depth_value = depth;
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_sent++;
    if (backproject(px, pt)) begin
      pending_points.push_back(pt);
    end else begin
      n_dropped++;
    end
  endtask

  task automatic send_random_pixel();
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [DEPTH_BITS-1:0] depth;
    col = COORD_BITS'($urandom);
    row = COORD_BITS'($urandom);
    // pull coordinates onto the image border now and then
    if ($urandom_range(0, 15) == 0) begin
      col = $urandom_range(0, 1) ? '1 : '0;
    end
    if ($urandom_range(0, 15) == 0) begin
      row = $urandom_range(0, 1) ? '1 : '0;
    end
    case ($urandom_range(0, 15))
      0:       depth = '0;
      1:       depth = '1;
      2:       depth = DEPTH_BITS'($urandom_range(1, 15));
      default: depth = DEPTH_BITS'($urandom_range(1, 65535));
    endcase
    send_pixel(col, row, depth);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure and the scoreboard
  // ---------------------------------------------------------------------------

  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  // Every output transfer is matched against the oldest owed point.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_points.size() == 0) begin
        flag_error($sformatf("unexpected point x=%0d y=%0d z=%0d",
                             out_data_o.point_x, out_data_o.point_y, out_data_o.point_z));
      end else begin
        want_pt = pending_points.pop_front();
        n_checked++;
        if (out_data_o.point_x !== want_pt.point_x ||
            out_data_o.point_y !== want_pt.point_y ||
            out_data_o.point_z !== want_pt.point_z) begin
          flag_error($sformatf("point %0d: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                               n_checked, want_pt.point_x, want_pt.point_y, want_pt.point_z,
                               out_data_o.point_x, out_data_o.point_y, out_data_o.point_z));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d points still owed",
               n_cycles, pending_points.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Register defaults: corners, principal point and a zero-depth pixel.
  task automatic test_reset_defaults();
    src_gap_pct    = 20;
    sink_stall_pct = 20;
    send_pixel('0, '0, 16'd1);
    send_pixel('1, '1, '1);
    send_pixel(12'd320, 12'd240, 16'd1000);  // on the optical axis
    send_pixel(12'd320, 12'd240, '0);        // zero depth: dropped
    send_pixel('1, '0, 16'h8000);
    send_pixel('0, '1, 16'd1);
  endtask

  // Extreme focal gain, centers and coefficients; drives saturation both ways.
  task automatic test_register_extremes();
    cfg_t c;
    c = reset_config();
    c.inv_focal  = '1;
    c.center_col = '0;
    c.center_row = '0;
    program_camera(c);
    send_pixel('1, '1, '1);                  // saturates high
    send_pixel('0, '0, '1);
    c.center_col = '1;
    c.center_row = '1;
    program_camera(c);
    send_pixel('0, '0, '1);                  // saturates low
    send_pixel('1, '1, 16'd1);
    c.inv_focal = '0;
    program_camera(c);
    send_pixel('1, '0, '1);                  // no lateral offset at all
    // rotation on with the identity rows
    c = reset_config();
    c.rotate_enable = 1'b1;
    program_camera(c);
    send_pixel(12'd320, 12'd240, 16'd1000);
    send_pixel('1, '1, '1);
    // matrix that is no rotation: full-scale coefficients of both signs
    c.rot_row[0] = {3{16'h7FFF}};
    c.rot_row[1] = {3{16'h8000}};
    c.rot_row[2] = {16'h8000, 16'h0000, 16'h7FFF};
    program_camera(c);
    send_pixel('1, '1, '1);
    send_pixel('0, '0, '1);
    send_pixel(12'd320, 12'd240, 16'd77);
  endtask

  // A write to the unmapped index must leave every register alone.
  task automatic test_unmapped_index();
    wait_pipeline_empty();
    write_reg(CFG_UNMAPPED, '1);
    cfg_we_i <= 1'b0;
    send_pixel(12'd100, 12'd200, 16'd500);
    send_pixel(12'd4000, 12'd10, 16'd60000);
  endtask

  // One register setting followed by a run of random pixels; halfway through
  // (and now and then at random) the sender holds off until all points are in.
  task automatic run_random_phase(input bit rotate, input int n_items);
    program_camera(random_config(rotate));
    src_gap_pct    = idle_levels[$urandom_range(0, 3)];
    sink_stall_pct = idle_levels[$urandom_range(0, 3)];
    for (int k = 0; k < n_items; k++) begin
      if (k == n_items / 2 || $urandom_range(0, 149) == 0) begin
        wait_pipeline_empty();
      end
      send_random_pixel();
    end
  endtask

  task automatic test_random_camera();
    repeat (4) run_random_phase(1'b0, 130);
  endtask

  task automatic test_random_rotation();
    repeat (4) run_random_phase(1'b1, 130);
  endtask

  // Last stretch: no idling on either side, one pixel per clock.
  task automatic test_streaming();
    program_camera(random_config(1'($urandom_range(0, 1))));
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    repeat (150) send_random_pixel();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    cam_cfg = reset_config();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_register_extremes();
    test_unmapped_index();
    test_random_camera();
    test_random_rotation();
    test_streaming();

    // drain everything still owed, then let the pipeline settle
    wait_pipeline_empty();

    $display("Sent %0d pixels (%0d zero-depth), checked %0d points", n_sent, n_dropped,
             n_checked);
    $display("Covered %0d register settings, camera and rotated frames, with back-pressure",
             n_settings);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches in total", n_errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
